### design/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared widths, stage payload types and helpers of the circle contact
// resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package ccr_pkg;

  localparam int unsigned ID_W       = 16;
  localparam int unsigned POS_W      = 22;
  localparam int unsigned DIAM_W     = 16;
  localparam int unsigned ABS_W      = 16;            // |d| when a contact is possible
  localparam int unsigned SQ_W       = 48;            // square-root operand width
  localparam int unsigned SQ_STEPS   = SQ_W / 2;      // one result bit per cell
  localparam int unsigned DIST_W     = SQ_W / 2;      // distance in Q.16
  localparam int unsigned QUO_W      = 16;            // correction magnitude bits
  localparam int unsigned DIVR_W     = DIST_W + 1;    // divisor 2*dist
  localparam int unsigned REM_W      = ABS_W + DIST_W + 1;
  localparam int unsigned DIST2_W    = 2 * POS_W + 1;
  localparam int unsigned DD_W       = 2 * DIAM_W;
  localparam int unsigned DIST2_EPS  = 6;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam logic        REG_DIAMETER = 1'b0;        // register index bit
  localparam logic [DIAM_W-1:0] DIAM_RESET = 16'd256;

  // Data that rides along the whole pipeline.
  typedef struct packed {
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y1;
    logic signed [POS_W-1:0] x2;
    logic signed [POS_W-1:0] y2;
    logic                    sx;
    logic                    sy;
    logic [ABS_W-1:0]        ax;
    logic [ABS_W-1:0]        ay;
    logic                    contact;
  } pass_t;

  // Square-root cell payload.
  typedef struct packed {
    pass_t           p;
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sq_t;

  // Divider cell payload, both axes side by side.
  typedef struct packed {
    pass_t             p;
    logic [DIVR_W-1:0] divr;
    logic [REM_W-1:0]  remx;
    logic [REM_W-1:0]  remy;
    logic [QUO_W-1:0]  qx;
    logic [QUO_W-1:0]  qy;
  } dv_t;

  // Clamp a 23-bit signed sum to the position range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    logic signed [POS_W:0] hi;
    logic signed [POS_W:0] lo;
    hi = (POS_W+1)'(signed'({1'b0, {(POS_W-1){1'b1}}}));
    lo = -hi - (POS_W+1)'(1);
    if (v > hi) begin
      sat_pos = hi[POS_W-1:0];
    end else if (v < lo) begin
      sat_pos = lo[POS_W-1:0];
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### design/ccr_if.sv
// ----------------------------------------------------------------------------
// ccr_pair_if / ccr_result_if
// Valid/ready channels for circle pairs and corrected positions.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccr_pair_if import ccr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ID_W-1:0]         first_id;
  logic [ID_W-1:0]         second_id;
  logic signed [POS_W-1:0] first_x;
  logic signed [POS_W-1:0] first_y;
  logic signed [POS_W-1:0] second_x;
  logic signed [POS_W-1:0] second_y;

  modport source (output valid, first_id, second_id, first_x, first_y, second_x,
                  second_y, input ready);
  modport sink (input valid, first_id, second_id, first_x, first_y, second_x,
                second_y, output ready);
endinterface

interface ccr_result_if import ccr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] new_first_x;
  logic signed [POS_W-1:0] new_first_y;
  logic signed [POS_W-1:0] new_second_x;
  logic signed [POS_W-1:0] new_second_y;
  logic                    contact;

  modport source (output valid, new_first_x, new_first_y, new_second_x, new_second_y,
                  contact, input ready);
  modport sink (input valid, new_first_x, new_first_y, new_second_x, new_second_y,
                contact, output ready);
endinterface

`default_nettype wire

### design/ccr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ccr_sqrt_cell
// One step of the bitwise integer square root: settles one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_sqrt_cell import ccr_pkg::*; #(
  parameter int unsigned BIT_IDX = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire sq_t  in_data,
  output logic      out_valid,
  output sq_t       out_data
);

  logic [SQ_W-1:0] bitv;
  logic [SQ_W:0]   trial;
  logic            take;
  sq_t             nxt;

  // Try to subtract root + 4^i from the remainder.
  always_comb begin
    bitv  = SQ_W'(1) << (2 * BIT_IDX);
    trial = {1'b0, in_data.root} + {1'b0, bitv};
    take  = {1'b0, in_data.rem} >= trial;
    nxt   = in_data;
    if (take) begin
      nxt.rem  = in_data.rem - trial[SQ_W-1:0];
      nxt.root = (in_data.root >> 1) + bitv;
    end else begin
      nxt.root = in_data.root >> 1;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

`default_nettype wire

### design/ccr_div_cell.sv
// ----------------------------------------------------------------------------
// ccr_div_cell
// One restoring division step for both axes: settles one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_div_cell import ccr_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire dv_t  in_data,
  output logic      out_valid,
  output dv_t       out_data
);

  logic [REM_W-1:0] trial;
  dv_t              nxt;

  // Compare each remainder against the shifted divisor.
  always_comb begin
    trial = REM_W'(in_data.divr) << SHIFT;
    nxt   = in_data;
    if (in_data.remx >= trial) begin
      nxt.remx        = in_data.remx - trial;
      nxt.qx[SHIFT]   = 1'b1;
    end
    if (in_data.remy >= trial) begin
      nxt.remy        = in_data.remy - trial;
      nxt.qy[SHIFT]   = 1'b1;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

`default_nettype wire

### design/circle_contact_resolver.sv
// ----------------------------------------------------------------------------
// circle_contact_resolver
// Pushes two overlapping equal circles apart along their center line.
//
//   Channel   Dir   Handshake          Carries
//   pair      in    valid/ready        two ids, two centers (Q13.8)
//   result    out   valid/ready        corrected centers, contact flag
//   apb       in    psel/penable       circle_diameter at address 0
//
// One transaction enters per cycle while the output does not stall. It passes
// three front stages, 24 square-root cells, one multiply stage, 16 divider
// cells and the output register. Each stage moves whenever the stage after
// it is empty or moving, so bubbles close up while the output stalls.
// Reset clears all valid bits and sets the diameter to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_contact_resolver import ccr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  ccr_pair_if.sink                pair,
  ccr_result_if.source            result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [DIAM_W-1:0] diameter;
  logic [DD_W-1:0]   dd;

  // Configuration register and its square.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      diameter <= DIAM_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DIAMETER) begin
      diameter <= pwdata[DIAM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    dd <= diameter * diameter;
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DIAMETER) begin
      prdata = PDATA_W'(diameter);
    end
  end

  // Stage valids and move enables.
  logic                va, vb, vc, vm, vo;
  logic                move_a, move_b, move_c, move_m, move_o;
  logic [SQ_STEPS-1:0] sv, move_s;
  logic [QUO_W-1:0]    dvv, move_d;

  assign move_o = !vo || result.ready;
  assign move_d[QUO_W-1] = !dvv[QUO_W-1] || move_o;
  for (genvar k = 0; k < QUO_W - 1; k++) begin : g_md
    assign move_d[k] = !dvv[k] || move_d[k+1];
  end
  assign move_m = !vm || move_d[0];
  assign move_s[SQ_STEPS-1] = !sv[SQ_STEPS-1] || move_m;
  for (genvar k = 0; k < SQ_STEPS - 1; k++) begin : g_ms
    assign move_s[k] = !sv[k] || move_s[k+1];
  end
  assign move_c = !vc || move_s[0];
  assign move_b = !vb || move_c;
  assign move_a = !va || move_b;
  assign pair.ready = move_a;

  // Stage A: differences and their magnitudes.
  pass_t                   a_p;
  logic [POS_W-1:0]        a_ax, a_ay;
  logic signed [POS_W:0]   dx, dy;

  always_comb begin
    dx = (POS_W+1)'(pair.first_x) - (POS_W+1)'(pair.second_x);
    dy = (POS_W+1)'(pair.first_y) - (POS_W+1)'(pair.second_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (move_a) begin
      va <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move_a) begin
      a_p.x1      <= pair.first_x;
      a_p.y1      <= pair.first_y;
      a_p.x2      <= pair.second_x;
      a_p.y2      <= pair.second_y;
      a_p.sx      <= dx[POS_W];
      a_p.sy      <= dy[POS_W];
      a_p.ax      <= '0;
      a_p.ay      <= '0;
      a_p.contact <= pair.first_id != pair.second_id;
      a_ax        <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
      a_ay        <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    end
  end

  // Stage B: squares.
  pass_t               b_p;
  pass_t               b_p_next;
  logic [2*POS_W-1:0]  b_sqx, b_sqy;

  always_comb begin
    b_p_next    = a_p;
    b_p_next.ax = a_ax[ABS_W-1:0];
    b_p_next.ay = a_ay[ABS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (move_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (move_b) begin
      b_p    <= b_p_next;
      b_sqx  <= a_ax * a_ax;
      b_sqy  <= a_ay * a_ay;
    end
  end

  // Stage C: overlap test and square-root operand.
  logic [DIST2_W-1:0] dist2;
  logic               hit;
  sq_t                s_in;
  sq_t                s_in_next;

  always_comb begin
    dist2 = DIST2_W'(b_sqx) + DIST2_W'(b_sqy);
    hit   = b_p.contact && dist2 < DIST2_W'(dd) && dist2 > DIST2_W'(DIST2_EPS);
    s_in_next           = '0;
    s_in_next.p         = b_p;
    s_in_next.p.contact = hit;
    s_in_next.p.ax      = hit ? b_p.ax : '0;
    s_in_next.p.ay      = hit ? b_p.ay : '0;
    s_in_next.rem       = hit ? {dist2[DD_W-1:0], 16'd0} : '0;
    s_in_next.root      = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (move_c) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (move_c) begin
      s_in <= s_in_next;
    end
  end

  // Square-root chain, most significant root bit first.
  sq_t s_out [SQ_STEPS];
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    if (k == 0) begin : g_first
      ccr_sqrt_cell #(.BIT_IDX(SQ_STEPS - 1 - k)) u_cell (
        .clk(clk), .rst(rst), .en(move_s[k]), .in_valid(vc), .in_data(s_in),
        .out_valid(sv[k]), .out_data(s_out[k]));
    end else begin : g_next
      ccr_sqrt_cell #(.BIT_IDX(SQ_STEPS - 1 - k)) u_cell (
        .clk(clk), .rst(rst), .en(move_s[k]), .in_valid(sv[k-1]),
        .in_data(s_out[k-1]), .out_valid(sv[k]), .out_data(s_out[k]));
    end
  end

  // Stage M: overlap times |d|, plus half the divisor for rounding.
  sq_t               s_last;
  logic [DIST_W-1:0] dist16;
  logic [DIST_W-1:0] num;
  dv_t               d_in;

  always_comb begin
    s_last = s_out[SQ_STEPS-1];
    dist16 = s_last.root[DIST_W-1:0];
    num    = {diameter, 8'd0} - dist16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (move_m) begin
      vm <= sv[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (move_m) begin
      d_in.p    <= s_last.p;
      d_in.divr <= {dist16, 1'b0};
      d_in.remx <= REM_W'(s_last.p.ax) * REM_W'(num) + REM_W'(dist16);
      d_in.remy <= REM_W'(s_last.p.ay) * REM_W'(num) + REM_W'(dist16);
      d_in.qx   <= '0;
      d_in.qy   <= '0;
    end
  end

  // Divider chain, most significant quotient bit first.
  dv_t d_out [QUO_W];
  for (genvar k = 0; k < QUO_W; k++) begin : g_dv
    if (k == 0) begin : g_first
      ccr_div_cell #(.SHIFT(QUO_W - 1 - k)) u_cell (
        .clk(clk), .rst(rst), .en(move_d[k]), .in_valid(vm), .in_data(d_in),
        .out_valid(dvv[k]), .out_data(d_out[k]));
    end else begin : g_next
      ccr_div_cell #(.SHIFT(QUO_W - 1 - k)) u_cell (
        .clk(clk), .rst(rst), .en(move_d[k]), .in_valid(dvv[k-1]),
        .in_data(d_out[k-1]), .out_valid(dvv[k]), .out_data(d_out[k]));
    end
  end

  // Output stage: signed correction and saturation.
  dv_t                   d_last;
  logic signed [POS_W:0] cx, cy;

  always_comb begin
    d_last = d_out[QUO_W-1];
    cx = d_last.p.sx ? -(POS_W+1)'(d_last.qx) : (POS_W+1)'(d_last.qx);
    cy = d_last.p.sy ? -(POS_W+1)'(d_last.qy) : (POS_W+1)'(d_last.qy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (move_o) begin
      vo <= dvv[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (move_o) begin
      result.contact <= d_last.p.contact;
      if (d_last.p.contact) begin
        result.new_first_x  <= sat_pos((POS_W+1)'(d_last.p.x1) + cx);
        result.new_first_y  <= sat_pos((POS_W+1)'(d_last.p.y1) + cy);
        result.new_second_x <= sat_pos((POS_W+1)'(d_last.p.x2) - cx);
        result.new_second_y <= sat_pos((POS_W+1)'(d_last.p.y2) - cy);
      end else begin
        result.new_first_x  <= d_last.p.x1;
        result.new_first_y  <= d_last.p.y1;
        result.new_second_x <= d_last.p.x2;
        result.new_second_y <= d_last.p.y2;
      end
    end
  end

  assign result.valid = vo;

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circle_contact_resolver. Circle pairs are driven
// on the pair channel with random idling, results are checked against an
// integer predictor of the overlap correction, and the diameter register is
// changed between phases over the APB port while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ccr_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] fx;
    logic signed [POS_W-1:0] fy;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic                    hit;
  } placement_t;

  // Tracks expected placements and counts mismatches.
  class contact_scoreboard;
    placement_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned contacts;
    logic [DIAM_W-1:0] diameter;

    function new();
      errors = 0;
      checked = 0;
      contacts = 0;
      diameter = DIAM_RESET;
    endfunction

    // Integer square root by the bit-pair method.
    static function longint unsigned root64(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function longint push(longint d, longint unsigned num, longint unsigned len16);
      longint unsigned mag;
      longint unsigned ad;
      ad = (d < 0) ? -d : d;
      mag = (ad * num + len16) / (2 * len16);
      return (d < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    static function logic signed [POS_W-1:0] clamp(longint v);
      if (v > 2097151) return POS_W'(2097151);
      if (v < -2097152) return POS_W'(-2097152);
      return v[POS_W-1:0];
    endfunction

    // Works out the corrected placement of one accepted pair.
    function void note_pair(logic [ID_W-1:0] id1, logic [ID_W-1:0] id2,
                            logic signed [POS_W-1:0] x1, logic signed [POS_W-1:0] y1,
                            logic signed [POS_W-1:0] x2, logic signed [POS_W-1:0] y2);
      placement_t p;
      longint dx;
      longint dy;
      longint cx;
      longint cy;
      longint unsigned d2;
      longint unsigned dd;
      longint unsigned len16;
      longint unsigned num;
      p = '{x1, y1, x2, y2, 1'b0};
      if (id1 != id2) begin
        dx = longint'(x1) - longint'(x2);
        dy = longint'(y1) - longint'(y2);
        d2 = dx * dx + dy * dy;
        dd = longint'(diameter) * longint'(diameter);
        if (d2 < dd && d2 > DIST2_EPS) begin
          len16 = root64(d2 << 16);
          num = (longint'(diameter) << 8) - len16;
          cx = push(dx, num, len16);
          cy = push(dy, num, len16);
          p.fx = clamp(x1 + cx);
          p.fy = clamp(y1 + cy);
          p.sx = clamp(x2 - cx);
          p.sy = clamp(y2 - cy);
          p.hit = 1'b1;
        end
      end
      pending.insert(pending.size(), p);
    endfunction

    // Compares one result with the oldest expectation.
    function void check_result(placement_t got);
      placement_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.hit) contacts++;
      if (got.fx !== exp.fx)
        $display("%0t: new_first_x expected %0d actual %0d", $time, exp.fx, got.fx);
      if (got.fy !== exp.fy)
        $display("%0t: new_first_y expected %0d actual %0d", $time, exp.fy, got.fy);
      if (got.sx !== exp.sx)
        $display("%0t: new_second_x expected %0d actual %0d", $time, exp.sx, got.sx);
      if (got.sy !== exp.sy)
        $display("%0t: new_second_y expected %0d actual %0d", $time, exp.sy, got.sy);
      if (got.hit !== exp.hit)
        $display("%0t: contact expected %0b actual %0b", $time, exp.hit, got.hit);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  ccr_pair_if pair ();
  ccr_result_if result ();

  circle_contact_resolver dut (
    .clk(clk), .rst(rst), .pair(pair.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  contact_scoreboard board;
  int unsigned send_idle;
  int unsigned take_idle;
  int unsigned pairs_sent;
  int unsigned diameters_used;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random; each handshake is checked.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready)
        board.check_result('{result.new_first_x, result.new_first_y, result.new_second_x,
                             result.new_second_y, result.contact});
      result.ready <= ($urandom_range(99) >= take_idle);
    end
  end

  // Drives one pair and holds it until accepted.
  task automatic send_pair(logic [ID_W-1:0] id1, logic [ID_W-1:0] id2,
                           logic signed [POS_W-1:0] x1, logic signed [POS_W-1:0] y1,
                           logic signed [POS_W-1:0] x2, logic signed [POS_W-1:0] y2);
    while ($urandom_range(99) < send_idle) begin
      pair.valid <= 1'b0;
      @(posedge clk);
    end
    pair.valid <= 1'b1;
    pair.first_id <= id1;
    pair.second_id <= id2;
    pair.first_x <= x1;
    pair.first_y <= y1;
    pair.second_x <= x2;
    pair.second_y <= y2;
    @(posedge clk);
    while (!pair.ready) @(posedge clk);
    board.note_pair(id1, id2, x1, y1, x2, y2);
    pairs_sent++;
  endtask

  // Lowers valid and waits for the pipeline to empty.
  task automatic drain();
    pair.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Writes the diameter over APB and reads it back.
  task automatic set_diameter(logic [DIAM_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[DIAM_W-1:0] !== value) begin
      $display("%0t: diameter readback expected %0d actual %0d", $time, value,
               prdata[DIAM_W-1:0]);
      board.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    board.diameter = value;
    diameters_used++;
  endtask

  // Random pair: mostly near each other so that contacts are frequent.
  task automatic random_pair();
    logic [ID_W-1:0] id1;
    logic [ID_W-1:0] id2;
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y1;
    int span;
    int sel;
    id1 = ID_W'($urandom);
    id2 = ($urandom_range(9) == 0) ? id1 : ID_W'($urandom);
    x1 = POS_W'($urandom);
    y1 = POS_W'($urandom);
    sel = $urandom_range(9);
    span = (sel < 7) ? int'(board.diameter) + 2 : (sel < 9 ? 8 : 0);
    if (span == 0)
      send_pair(id1, id2, x1, y1, POS_W'($urandom), POS_W'($urandom));
    else
      send_pair(id1, id2, x1, y1,
                x1 + POS_W'($urandom_range(2 * span) - span),
                y1 + POS_W'($urandom_range(2 * span) - span));
  endtask

  initial begin
    #2000000;
    $display("[circle_contact_resolver] ERROR");
    $finish;
  end

  initial begin
    logic [DIAM_W-1:0] diam_list[5];
    board = new();
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pair.valid = 1'b0;
    pair.first_id = '0;
    pair.second_id = '0;
    pair.first_x = '0;
    pair.first_y = '0;
    pair.second_x = '0;
    pair.second_y = '0;
    send_idle = 32;
    take_idle = 66;
    pairs_sent = 0;
    diameters_used = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pairs at the reset diameter of 1.0.
    send_pair(16'd5, 16'd5, 22'sd0, 22'sd0, 22'sd10, 22'sd0);
    send_pair(16'd0, 16'hFFFF, 22'sd0, 22'sd0, 22'sd100, 22'sd0);
    send_pair(16'd1, 16'd2, 22'sd0, 22'sd0, 22'sd0, -22'sd100);
    send_pair(16'd1, 16'd2, 22'sd50, 22'sd50, -22'sd50, -22'sd50);
    send_pair(16'd1, 16'd2, 22'sd0, 22'sd0, 22'sd2, 22'sd1);
    send_pair(16'd1, 16'd2, 22'sd0, 22'sd0, 22'sd2, 22'sd2);
    send_pair(16'd1, 16'd2, 22'sd0, 22'sd0, 22'sd0, 22'sd0);
    send_pair(16'd1, 16'd2, 22'sd0, 22'sd0, 22'sd256, 22'sd0);
    send_pair(16'd1, 16'd2, 22'sd0, 22'sd0, 22'sd255, 22'sd0);
    send_pair(16'd1, 16'd2, 22'sd2097151, 22'sd2097151, 22'sd2097100, 22'sd2097120);
    send_pair(16'd1, 16'd2, -22'sd2097152, -22'sd2097152, -22'sd2097100, -22'sd2097130);
    send_pair(16'hFFFF, 16'd0, 22'sd2097151, -22'sd2097152, -22'sd2097152, 22'sd2097151);
    send_pair(16'hAAAA, 16'h5555, 22'sd1000, 22'sd1000, 22'sd1001, 22'sd999);
    drain();

    // Random phases over several diameters, including both extremes and zero.
    diam_list = '{16'd1, 16'hFFFF, 16'd0, 16'd40, 16'd256};
    foreach (diam_list[k]) begin
      set_diameter(diam_list[k]);
      if (k == 1) begin
        send_pair(16'd1, 16'd2, 22'sd2097151, 22'sd2097151, 22'sd2097151 - 22'sd30000,
                  22'sd2097151 - 22'sd30000);
        send_pair(16'd1, 16'd2, -22'sd2097152, 22'sd0, -22'sd2097152 + 22'sd1000, 22'sd5);
      end
      if (k == 2) begin
        send_idle = 66;
        take_idle = 32;
      end
      if (k == 4) begin
        send_idle = 0;
        take_idle = 0;
      end
      for (int n = 0; n < 140; n++) begin
        random_pair();
        if (n == 70) drain();
      end
      drain();
    end

    $display("Checked %0d results (%0d contacts) from %0d pairs over %0d diameters.",
             board.checked, board.contacts, pairs_sent, diameters_used + 1);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[circle_contact_resolver] OK");
    end else begin
      $display("[circle_contact_resolver] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
